/* rtl/npcm_pkg.sv */
// ----------------------------------------------------------------------------
// npcm_pkg
// Shared types and constants for the nearest palette colour match block.
// ----------------------------------------------------------------------------
package npcm_pkg;

    // Fixed field widths of the item interface
    localparam int IDX_BITS  = 8;
    localparam int DIST_BITS = 14;
    localparam int CFG_BITS  = 8;

    // Item function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic CFG_SEARCH_FIRST = 1'b0;
    localparam logic CFG_SEARCH_LAST  = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic wr_en;     // store the incoming entry
        logic rd_en;     // read one palette entry into the pipeline
        logic rd_last;   // this read is the last of the scan
        logic start;     // latch query colour, clear best
        logic load_out;  // move best into the output register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic scan_done; // last entry is in the compare stage
        logic out_free;  // output register can take a new result
    } t_sts;

endpackage

/* rtl/npcm_ctrl.sv */
// ----------------------------------------------------------------------------
// npcm_ctrl
// Controller: configuration registers, range check and scan sequencing.
// ----------------------------------------------------------------------------
module npcm_ctrl import npcm_pkg::*; #(
    parameter int PALETTE_SIZE = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic                              i_func,
    input  logic [IDX_BITS-1:0]               i_entry_index,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_addr,
    input  logic [CFG_BITS-1:0]               i_cfg_data,
    input  t_sts                              i_sts,
    output logic                              o_stall,
    output t_cmd                              o_cmd,
    output logic [$clog2(PALETTE_SIZE)-1:0]   o_addr
);

    localparam int AW = $clog2(PALETTE_SIZE);
    localparam int RW = (AW > IDX_BITS) ? AW : IDX_BITS;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_RESULT = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [AW-1:0]       r_addr, n_addr;
    logic [AW-1:0]       r_last_addr, n_last_addr;
    logic [IDX_BITS-1:0] r_search_first;
    logic [IDX_BITS-1:0] r_search_last;

    logic          w_accept;
    logic [RW-1:0] w_first_x;
    logic [RW-1:0] w_last_x;
    logic [RW-1:0] w_entry_x;
    logic [RW-1:0] w_pmax;
    logic [RW-1:0] w_last_clamp;
    logic          w_empty;
    logic          w_wr_ok;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_search_first <= IDX_BITS'(0);
            r_search_last  <= IDX_BITS'(31);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_SEARCH_FIRST: r_search_first <= i_cfg_data;
                CFG_SEARCH_LAST:  r_search_last  <= i_cfg_data;
                default:          r_search_first <= r_search_first;
            endcase
        end
    end

    // Range clamp and empty check
    assign w_first_x    = RW'(r_search_first);
    assign w_last_x     = RW'(r_search_last);
    assign w_entry_x    = RW'(i_entry_index);
    assign w_pmax       = RW'(PALETTE_SIZE - 1);
    assign w_last_clamp = (w_last_x > w_pmax) ? w_pmax : w_last_x;
    assign w_empty      = (w_first_x > w_last_clamp);
    assign w_wr_ok      = (w_entry_x <= w_pmax);

    assign o_stall  = (r_state != ST_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign o_addr   = (r_state == ST_IDLE) ? w_entry_x[AW-1:0] : r_addr;

    // Next-state logic
    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_last_addr = r_last_addr;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_func == FUNC_WRITE) begin
                        o_cmd.wr_en = w_wr_ok;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_addr      = w_first_x[AW-1:0];
                        n_last_addr = w_last_clamp[AW-1:0];
                        n_state     = w_empty ? ST_RESULT : ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_last = (r_addr == r_last_addr);
                if (r_addr == r_last_addr) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (i_sts.scan_done) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Scan pointers carry no reset
    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_last_addr <= n_last_addr;
    end

    // Reads and writes never share a cycle
    a_rd_wr_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.rd_en && o_cmd.wr_en))
        else $error("palette read and write in the same cycle");

    // Completion only arrives while waiting for it
    a_done_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.scan_done |-> (r_state == ST_DRAIN))
        else $error("scan completion outside drain");

    // Last read of a scan is followed by the drain wait
    a_last_to_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_last |=> (r_state == ST_DRAIN))
        else $error("scan did not stop after last read");

endmodule

/* rtl/npcm_datapath.sv */
// ----------------------------------------------------------------------------
// npcm_datapath
// Palette memory, pipelined distance unit, best tracker and output register.
// ----------------------------------------------------------------------------
module npcm_datapath import npcm_pkg::*; #(
    parameter int PALETTE_SIZE   = 256,
    parameter int COMPONENT_BITS = 6
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  t_cmd                              i_cmd,
    input  logic [$clog2(PALETTE_SIZE)-1:0]   i_addr,
    input  logic [COMPONENT_BITS-1:0]         i_red,
    input  logic [COMPONENT_BITS-1:0]         i_green,
    input  logic [COMPONENT_BITS-1:0]         i_blue,
    input  logic                              i_stall,
    output t_sts                              o_sts,
    output logic                              o_valid,
    output logic [IDX_BITS-1:0]               o_best_index,
    output logic [DIST_BITS-1:0]              o_best_distance,
    output logic                              o_found
);

    localparam int AW   = $clog2(PALETTE_SIZE);
    localparam int CB   = COMPONENT_BITS;
    localparam int SQ_W = 2 * CB;
    localparam int DW   = 2 * CB + 2;

    // Palette storage, red in the high bits
    logic [3*CB-1:0] r_mem [PALETTE_SIZE];

    // Query colour
    logic [CB-1:0] r_q_r, r_q_g, r_q_b;

    // Stage 1: read data
    logic            r_v1, r_last1;
    logic [AW-1:0]   r_idx1;
    logic [3*CB-1:0] r_ent1;

    // Stage 2: squared differences
    logic            r_v2, r_last2;
    logic [AW-1:0]   r_idx2;
    logic [SQ_W-1:0] r_sq_r, r_sq_g, r_sq_b;

    // Stage 3: distance
    logic            r_v3, r_last3;
    logic [AW-1:0]   r_idx3;
    logic [DW-1:0]   r_sum3;

    // Best so far
    logic            r_found;
    logic [AW-1:0]   r_best_i;
    logic [DW-1:0]   r_best_d;

    // Output register
    logic                 r_out_valid;
    logic [IDX_BITS-1:0]  r_out_index;
    logic [DIST_BITS-1:0] r_out_dist;
    logic                 r_out_found;

    logic [CB-1:0] w_er, w_eg, w_eb;
    logic [CB-1:0] w_dr, w_dg, w_db;
    logic          w_better;

    // Memory write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_addr] <= {i_red, i_green, i_blue};
        end
        if (i_cmd.rd_en) begin
            r_ent1 <= r_mem[i_addr];
        end
    end

    // Query colour latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_q_r <= i_red;
            r_q_g <= i_green;
            r_q_b <= i_blue;
        end
    end

    // Absolute component differences
    assign w_er = r_ent1[3*CB-1:2*CB];
    assign w_eg = r_ent1[2*CB-1:CB];
    assign w_eb = r_ent1[CB-1:0];
    assign w_dr = (r_q_r > w_er) ? (r_q_r - w_er) : (w_er - r_q_r);
    assign w_dg = (r_q_g > w_eg) ? (r_q_g - w_eg) : (w_eg - r_q_g);
    assign w_db = (r_q_b > w_eb) ? (r_q_b - w_eb) : (w_eb - r_q_b);

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        r_idx1 <= i_addr;
        r_sq_r <= SQ_W'(w_dr) * SQ_W'(w_dr);
        r_sq_g <= SQ_W'(w_dg) * SQ_W'(w_dg);
        r_sq_b <= SQ_W'(w_db) * SQ_W'(w_db);
        r_idx2 <= r_idx1;
        r_sum3 <= DW'(r_sq_r) + DW'(r_sq_g) + DW'(r_sq_b);
        r_idx3 <= r_idx2;
    end

    // Pipeline valid and last flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_last1 <= 1'b0;
            r_last2 <= 1'b0;
            r_last3 <= 1'b0;
        end else begin
            r_v1    <= i_cmd.rd_en;
            r_last1 <= i_cmd.rd_en && i_cmd.rd_last;
            r_v2    <= r_v1;
            r_last2 <= r_last1;
            r_v3    <= r_v2;
            r_last3 <= r_last2;
        end
    end

    // Strict compare: lower index wins ties
    assign w_better = r_v3 && (!r_found || (r_sum3 < r_best_d));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.start) begin
            r_found <= 1'b0;
        end else if (w_better) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_best_i <= '0;
            r_best_d <= '0;
        end else if (w_better) begin
            r_best_i <= r_idx3;
            r_best_d <= r_sum3;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_index <= IDX_BITS'(r_best_i);
            r_out_dist  <= DIST_BITS'(r_best_d);
            r_out_found <= r_found;
        end
    end

    assign o_sts.scan_done = r_v3 && r_last3;
    assign o_sts.out_free  = !r_out_valid || !i_stall;

    assign o_valid         = r_out_valid;
    assign o_best_index    = r_out_index;
    assign o_best_distance = r_out_dist;
    assign o_found         = r_out_found;

    // Best distance never grows during a scan
    a_best_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_found && !i_cmd.start) |=> (r_best_d <= $past(r_best_d)))
        else $error("best distance increased during scan");

    // A loaded result is presented next cycle
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> o_valid)
        else $error("loaded result not presented");

    // A result is never overwritten while waiting to be taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || !i_stall))
        else $error("pending result overwritten");

endmodule

/* rtl/nearest_palette_color_match.sv */
// A palette write does not stall the input; the next item can follow on the next cycle.
// A query reads the entries of the search range one per cycle through a single read port
// and distance pipeline, then waits for the last entry to reach the compare stage.
// An empty range goes to the result without a palette read. The next item is accepted
// on the cycle after the result is loaded, even if that result is still waiting to be taken.
// Synchronous active-low reset: search range 0..31, no result pending; palette undefined.
// ----------------------------------------------------------------------------
// nearest_palette_color_match
// Palette store with nearest colour search by squared Euclidean distance.
// ----------------------------------------------------------------------------
module nearest_palette_color_match import npcm_pkg::*; #(
    parameter int PALETTE_SIZE   = 256,
    parameter int COMPONENT_BITS = 6
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Input item channel
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_func,
    input  logic [IDX_BITS-1:0]       i_entry_index,
    input  logic [COMPONENT_BITS-1:0] i_red,
    input  logic [COMPONENT_BITS-1:0] i_green,
    input  logic [COMPONENT_BITS-1:0] i_blue,
    // Result item channel
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [IDX_BITS-1:0]       o_best_index,
    output logic [DIST_BITS-1:0]      o_best_distance,
    output logic                      o_found,
    // Configuration port
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_addr,
    input  logic [CFG_BITS-1:0]       i_cfg_data
);

    localparam int AW = $clog2(PALETTE_SIZE);

    t_cmd          w_cmd;
    t_sts          w_sts;
    logic [AW-1:0] w_addr;

    npcm_ctrl #(
        .PALETTE_SIZE (PALETTE_SIZE)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_func        (i_func),
        .i_entry_index (i_entry_index),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .i_sts         (w_sts),
        .o_stall       (o_stall),
        .o_cmd         (w_cmd),
        .o_addr        (w_addr)
    );

    npcm_datapath #(
        .PALETTE_SIZE   (PALETTE_SIZE),
        .COMPONENT_BITS (COMPONENT_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_addr          (w_addr),
        .i_red           (i_red),
        .i_green         (i_green),
        .i_blue          (i_blue),
        .i_stall         (i_stall),
        .o_sts           (w_sts),
        .o_valid         (o_valid),
        .o_best_index    (o_best_index),
        .o_best_distance (o_best_distance),
        .o_found         (o_found)
    );

endmodule
